[rtl/core/tf256_pkg.sv]
// Shared types and constants for the Threefish-256 cipher core.
// Used by the key schedule, the round cell and the top level.
// No dependencies.
package tf256_pkg;

  localparam int WORD_W      = 64;
  localparam int NUM_WORDS   = 4;
  localparam int NUM_ROUNDS  = 72;
  localparam int LAST_SUBKEY = 18;
  localparam int NUM_SUBKEYS = LAST_SUBKEY + 1;
  // One pre-whitening cell, one cell per round, one post-whitening cell.
  localparam int NUM_CELLS   = NUM_ROUNDS + 2;
  localparam int ROT_W       = 6;
  localparam int CFG_IDX_W   = 3;

  localparam logic [WORD_W-1:0] KEY_PARITY = 64'h1BD1_1BDA_A9FC_1A22;

  localparam logic [ROT_W-1:0] ROT_A [8] = '{6'd14, 6'd52, 6'd23, 6'd5,
                                             6'd25, 6'd46, 6'd58, 6'd32};
  localparam logic [ROT_W-1:0] ROT_B [8] = '{6'd16, 6'd57, 6'd40, 6'd37,
                                             6'd33, 6'd12, 6'd22, 6'd32};

  typedef enum logic {
    CMD_ENC = 1'b0,
    CMD_DEC = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0   = 3'd0,
    CFG_KEY1   = 3'd1,
    CFG_KEY2   = 3'd2,
    CFG_KEY3   = 3'd3,
    CFG_TWEAK0 = 3'd4,
    CFG_TWEAK1 = 3'd5
  } cfg_idx_t;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] block_t;
  typedef block_t [NUM_SUBKEYS-1:0] sched_t;

  typedef struct packed {
    cmd_t   cmd;
    block_t words;
  } item_t;

  // Per-cell round setup: rotation amounts and subkey injection for
  // both directions.
  typedef struct packed {
    logic             mix_en;
    logic [ROT_W-1:0] rot_a_enc;
    logic [ROT_W-1:0] rot_b_enc;
    logic [ROT_W-1:0] rot_a_dec;
    logic [ROT_W-1:0] rot_b_dec;
    logic             key_enc;
    logic             key_dec;
    block_t           sk_enc;
    block_t           sk_dec;
  } cell_ctl_t;

endpackage

[rtl/core/tf256_keysched.sv]
// Key and tweak registers plus the registered table of all 19 subkeys.
// The table is computed from the post-write register values so it is
// current at the same edge as the write. Depends on tf256_pkg.
module tf256_keysched (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [tf256_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tf256_pkg::WORD_W-1:0]         cfg_wdata,
  output tf256_pkg::sched_t                    subkeys
);

  logic [3:0][tf256_pkg::WORD_W-1:0] key_r, key_nxt;
  logic [1:0][tf256_pkg::WORD_W-1:0] tweak_r, tweak_nxt;
  logic [4:0][tf256_pkg::WORD_W-1:0] ks;
  logic [2:0][tf256_pkg::WORD_W-1:0] ts;
  tf256_pkg::sched_t                 sk_r, sk_nxt;

  always_comb begin
    key_nxt   = key_r;
    tweak_nxt = tweak_r;
    if (!rst_n) begin
      key_nxt   = '0;
      tweak_nxt = '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tf256_pkg::CFG_KEY0:   key_nxt[0]   = cfg_wdata;
        tf256_pkg::CFG_KEY1:   key_nxt[1]   = cfg_wdata;
        tf256_pkg::CFG_KEY2:   key_nxt[2]   = cfg_wdata;
        tf256_pkg::CFG_KEY3:   key_nxt[3]   = cfg_wdata;
        tf256_pkg::CFG_TWEAK0: tweak_nxt[0] = cfg_wdata;
        tf256_pkg::CFG_TWEAK1: tweak_nxt[1] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    ks[3:0] = key_nxt;
    ks[4]   = tf256_pkg::KEY_PARITY ^ key_nxt[0] ^ key_nxt[1] ^ key_nxt[2] ^ key_nxt[3];
    ts[1:0] = tweak_nxt;
    ts[2]   = tweak_nxt[0] ^ tweak_nxt[1];
  end

  for (genvar s = 0; s < tf256_pkg::NUM_SUBKEYS; s++) begin : g_sk
    assign sk_nxt[s][0] = ks[s % 5];
    assign sk_nxt[s][1] = ks[(s + 1) % 5] + ts[s % 3];
    assign sk_nxt[s][2] = ks[(s + 2) % 5] + ts[(s + 1) % 3];
    assign sk_nxt[s][3] = ks[(s + 3) % 5] + tf256_pkg::WORD_W'(s);
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    tweak_r <= tweak_nxt;
    sk_r    <= sk_nxt;
  end

  assign subkeys = sk_r;

endmodule

[rtl/core/tf256_cell.sv]
// One stage of the cipher chain: optional subkey injection and an optional
// MIX round (forward or inverse, chosen per transaction), then a register.
// Depends on tf256_pkg.
module tf256_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tf256_pkg::cell_ctl_t ctl,
  input  logic                 up_valid,
  input  tf256_pkg::item_t     up_item,
  output logic                 up_ready,
  output logic                 dn_valid,
  output tf256_pkg::item_t     dn_item,
  input  logic                 dn_ready
);

  logic             valid_r, valid_nxt;
  tf256_pkg::item_t item_r;
  tf256_pkg::block_t x, k, y;

  function automatic logic [tf256_pkg::WORD_W-1:0] rotl(
    input logic [tf256_pkg::WORD_W-1:0] v,
    input logic [tf256_pkg::ROT_W-1:0]  r
  );
    return (v << r) | (v >> (7'd64 - {1'b0, r}));
  endfunction

  function automatic logic [tf256_pkg::WORD_W-1:0] rotr(
    input logic [tf256_pkg::WORD_W-1:0] v,
    input logic [tf256_pkg::ROT_W-1:0]  r
  );
    return (v >> r) | (v << (7'd64 - {1'b0, r}));
  endfunction

  always_comb begin
    x = up_item.words;
    k = x;
    y = x;
    if (up_item.cmd == tf256_pkg::CMD_ENC) begin
      if (ctl.key_enc) begin
        for (int i = 0; i < tf256_pkg::NUM_WORDS; i++) begin
          k[i] = x[i] + ctl.sk_enc[i];
        end
      end
      y = k;
      if (ctl.mix_en) begin
        // MIX on both pairs, then words 1 and 3 trade places.
        y[0] = k[0] + k[1];
        y[2] = k[2] + k[3];
        y[3] = rotl(k[1], ctl.rot_a_enc) ^ y[0];
        y[1] = rotl(k[3], ctl.rot_b_enc) ^ y[2];
      end
    end else begin
      k = x;
      if (ctl.mix_en) begin
        k[1] = rotr(x[3] ^ x[0], ctl.rot_a_dec);
        k[0] = x[0] - k[1];
        k[3] = rotr(x[1] ^ x[2], ctl.rot_b_dec);
        k[2] = x[2] - k[3];
      end
      y = k;
      if (ctl.key_dec) begin
        for (int i = 0; i < tf256_pkg::NUM_WORDS; i++) begin
          y[i] = k[i] - ctl.sk_dec[i];
        end
      end
    end
  end

  // A cell takes a new transaction when it is empty or its content moves on.
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r.cmd   <= up_item.cmd;
      item_r.words <= y;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

[rtl/core/threefish256_block_cipher.sv]
// Top level of the Threefish-256 cipher core: key schedule plus a chain
// of 74 cells. Depends on tf256_pkg, tf256_keysched and tf256_cell.
//
// Usage:
//   Input channel (in_valid / in_stall): one 256-bit block as four words
//   and a direction, in_cmd 0 to encrypt and 1 to decrypt. A transaction
//   completes on a rising edge with in_valid high and in_stall low.
//   Result channel (out_valid / out_stall): one 256-bit block per input,
//   in input order.
//   Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
//   (0..3 key words, 4..5 tweak words; other indexes are ignored). Write
//   only while no transaction is in flight.
// Pipeline:
//   A block accepted on an edge passes through one cell for the decryption
//   subkey step, 72 round cells and one cell for the encryption subkey
//   step before it reaches the out_ ports. Each cell holds one block, so a
//   new block is accepted every cycle unless a stall has filled the chain.
// Reset (rst_n low, synchronous) empties the chain and clears all key and
// tweak words to zero. When the receiver stalls, the result holds on the
// out_ ports; cells behind it keep filling until the chain is full, and
// only then is in_stall raised.
module threefish256_block_cipher (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [tf256_pkg::WORD_W-1:0]       in_block_word_0,
  input  logic [tf256_pkg::WORD_W-1:0]       in_block_word_1,
  input  logic [tf256_pkg::WORD_W-1:0]       in_block_word_2,
  input  logic [tf256_pkg::WORD_W-1:0]       in_block_word_3,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tf256_pkg::WORD_W-1:0]       out_word_0,
  output logic [tf256_pkg::WORD_W-1:0]       out_word_1,
  output logic [tf256_pkg::WORD_W-1:0]       out_word_2,
  output logic [tf256_pkg::WORD_W-1:0]       out_word_3,
  input  logic                               cfg_wr_en,
  input  logic [tf256_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tf256_pkg::WORD_W-1:0]       cfg_wdata
);

  localparam int NC = tf256_pkg::NUM_CELLS;

  tf256_pkg::sched_t    subkeys;
  tf256_pkg::cell_ctl_t ctl_c   [NC];
  logic                 valid_c [NC+1];
  logic                 ready_c [NC+1];
  tf256_pkg::item_t     item_c  [NC+1];

  tf256_keysched u_keysched (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .subkeys   (subkeys)
  );

  assign valid_c[0]          = in_valid;
  assign item_c[0].cmd       = tf256_pkg::cmd_t'(in_cmd);
  assign item_c[0].words[0]  = in_block_word_0;
  assign item_c[0].words[1]  = in_block_word_1;
  assign item_c[0].words[2]  = in_block_word_2;
  assign item_c[0].words[3]  = in_block_word_3;
  assign in_stall            = !ready_c[0];
  assign ready_c[NC]         = !out_stall;

  for (genvar c = 0; c < NC; c++) begin : g_cell
    if (c == 0) begin : g_pre
      // Decryption strips the last subkey before the inverse rounds.
      assign ctl_c[c].mix_en    = 1'b0;
      assign ctl_c[c].rot_a_enc = '0;
      assign ctl_c[c].rot_b_enc = '0;
      assign ctl_c[c].rot_a_dec = '0;
      assign ctl_c[c].rot_b_dec = '0;
      assign ctl_c[c].key_enc   = 1'b0;
      assign ctl_c[c].key_dec   = 1'b1;
      assign ctl_c[c].sk_enc    = subkeys[tf256_pkg::LAST_SUBKEY];
      assign ctl_c[c].sk_dec    = subkeys[tf256_pkg::LAST_SUBKEY];
    end else if (c == NC - 1) begin : g_post
      // Encryption adds the last subkey after round 71.
      assign ctl_c[c].mix_en    = 1'b0;
      assign ctl_c[c].rot_a_enc = '0;
      assign ctl_c[c].rot_b_enc = '0;
      assign ctl_c[c].rot_a_dec = '0;
      assign ctl_c[c].rot_b_dec = '0;
      assign ctl_c[c].key_enc   = 1'b1;
      assign ctl_c[c].key_dec   = 1'b0;
      assign ctl_c[c].sk_enc    = subkeys[tf256_pkg::LAST_SUBKEY];
      assign ctl_c[c].sk_dec    = subkeys[tf256_pkg::LAST_SUBKEY];
    end else begin : g_round
      // Forward round index and the inverse round index run opposite ways.
      localparam int RE = c - 1;
      localparam int RD = tf256_pkg::NUM_ROUNDS - c;
      assign ctl_c[c].mix_en    = 1'b1;
      assign ctl_c[c].rot_a_enc = tf256_pkg::ROT_A[RE % 8];
      assign ctl_c[c].rot_b_enc = tf256_pkg::ROT_B[RE % 8];
      assign ctl_c[c].rot_a_dec = tf256_pkg::ROT_A[RD % 8];
      assign ctl_c[c].rot_b_dec = tf256_pkg::ROT_B[RD % 8];
      assign ctl_c[c].key_enc   = (RE % 4) == 0;
      assign ctl_c[c].key_dec   = (RD % 4) == 0;
      assign ctl_c[c].sk_enc    = subkeys[RE / 4];
      assign ctl_c[c].sk_dec    = subkeys[RD / 4];
    end

    tf256_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl_c[c]),
      .up_valid (valid_c[c]),
      .up_item  (item_c[c]),
      .up_ready (ready_c[c]),
      .dn_valid (valid_c[c+1]),
      .dn_item  (item_c[c+1]),
      .dn_ready (ready_c[c+1])
    );
  end

  assign out_valid  = valid_c[NC];
  assign out_word_0 = item_c[NC].words[0];
  assign out_word_1 = item_c[NC].words[1];
  assign out_word_2 = item_c[NC].words[2];
  assign out_word_3 = item_c[NC].words[3];

endmodule

[bench/testbench.sv]
// Self-checking testbench for the Threefish-256 block cipher core.
// Needs tf256_pkg and threefish256_block_cipher; results are predicted in
// the bench and compared word by word against the result channel.
`timescale 1ns / 100ps

module testbench;
  import tf256_pkg::*;

  localparam int LATENCY        = 73;
  localparam int DRAIN_CYCLES   = LATENCY + 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_LIMIT   = 10;

  typedef enum int {
    SET_KEEP,
    SET_ZERO,
    SET_ONES,
    SET_RANDOM,
    SET_MIXED
  } cfg_set_t;

  class cipher_scoreboard;
    logic [WORD_W-1:0] key_words [4];
    logic [WORD_W-1:0] tweak_words [2];
    block_t            expected_blocks [$];
    int unsigned       mismatches;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      foreach (tweak_words[i]) tweak_words[i] = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: key_words[idx[1:0]] = data;
        CFG_TWEAK0: tweak_words[0] = data;
        CFG_TWEAK1: tweak_words[1] = data;
        default: ;
      endcase
    endfunction

    function logic [WORD_W-1:0] rol64(logic [WORD_W-1:0] x, logic [ROT_W-1:0] r);
      if (r == 0) return x;
      return (x << r) | (x >> (WORD_W - r));
    endfunction

    function logic [WORD_W-1:0] ror64(logic [WORD_W-1:0] x, logic [ROT_W-1:0] r);
      if (r == 0) return x;
      return (x >> r) | (x << (WORD_W - r));
    endfunction

    // Subkey s is built from the extended key (with the parity word) and the
    // extended tweak (with T0 ^ T1), both taken from the current registers.
    function block_t round_key(int unsigned s);
      logic [WORD_W-1:0] ks [5];
      logic [WORD_W-1:0] ts [3];
      block_t            sk;
      ks[4] = KEY_PARITY;
      for (int i = 0; i < NUM_WORDS; i++) begin
        ks[i] = key_words[i];
        ks[4] ^= key_words[i];
      end
      ts[0] = tweak_words[0];
      ts[1] = tweak_words[1];
      ts[2] = ts[0] ^ ts[1];
      for (int i = 0; i < NUM_WORDS; i++) sk[i] = ks[(s + i) % 5];
      sk[1] += ts[s % 3];
      sk[2] += ts[(s + 1) % 3];
      sk[3] += WORD_W'(s);
      return sk;
    endfunction

    function block_t threefish(cmd_t dir, block_t b);
      block_t            x;
      block_t            sk;
      logic [WORD_W-1:0] t;
      x = b;
      if (dir == CMD_ENC) begin
        for (int n = 0; n < NUM_ROUNDS; n++) begin
          if (n % 4 == 0) begin
            sk = round_key(n / 4);
            for (int i = 0; i < NUM_WORDS; i++) x[i] += sk[i];
          end
          x[0] += x[1];
          x[1] = rol64(x[1], ROT_A[n % 8]) ^ x[0];
          x[2] += x[3];
          x[3] = rol64(x[3], ROT_B[n % 8]) ^ x[2];
          t = x[1]; x[1] = x[3]; x[3] = t;
        end
        sk = round_key(LAST_SUBKEY);
        for (int i = 0; i < NUM_WORDS; i++) x[i] += sk[i];
      end else begin
        sk = round_key(LAST_SUBKEY);
        for (int i = 0; i < NUM_WORDS; i++) x[i] -= sk[i];
        for (int n = NUM_ROUNDS - 1; n >= 0; n--) begin
          t = x[1]; x[1] = x[3]; x[3] = t;
          x[1] = ror64(x[1] ^ x[0], ROT_A[n % 8]);
          x[0] -= x[1];
          x[3] = ror64(x[3] ^ x[2], ROT_B[n % 8]);
          x[2] -= x[3];
          if (n % 4 == 0) begin
            sk = round_key(n / 4);
            for (int i = 0; i < NUM_WORDS; i++) x[i] -= sk[i];
          end
        end
      end
      return x;
    endfunction

    function void note_block(cmd_t dir, block_t b);
      expected_blocks.push_back(threefish(dir, b));
    endfunction

    function void check_block(block_t got);
      block_t         want;
      logic [NUM_WORDS-1:0] bad;
      if (expected_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with no block outstanding: %h", $time, got);
        return;
      end
      want = expected_blocks.pop_front();
      for (int i = 0; i < NUM_WORDS; i++) bad[i] = (got[i] !== want[i]);
      if (bad != 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result words differ (mask %b)", $time, bad);
          $display("  expected %h %h %h %h", want[0], want[1], want[2], want[3]);
          $display("  actual   %h %h %h %h", got[0], got[1], got[2], got[3]);
        end
      end
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_cmd;
  logic [WORD_W-1:0]    in_block_word_0;
  logic [WORD_W-1:0]    in_block_word_1;
  logic [WORD_W-1:0]    in_block_word_2;
  logic [WORD_W-1:0]    in_block_word_3;
  logic                 out_valid;
  logic                 out_stall;
  logic [WORD_W-1:0]    out_word_0;
  logic [WORD_W-1:0]    out_word_1;
  logic [WORD_W-1:0]    out_word_2;
  logic [WORD_W-1:0]    out_word_3;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;

  cipher_scoreboard sb = new();
  bit               idle_on = 1'b1;
  int unsigned      stall_odds = 8;
  int unsigned      gap_odds = 4;
  int unsigned      quiet_cycles = 0;

  always #2 clk = ~clk;

  threefish256_block_cipher DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_block_word_0 (in_block_word_0),
    .in_block_word_1 (in_block_word_1),
    .in_block_word_2 (in_block_word_2),
    .in_block_word_3 (in_block_word_3),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word_0      (out_word_0),
    .out_word_1      (out_word_1),
    .out_word_2      (out_word_2),
    .out_word_3      (out_word_3),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Mostly full-entropy words, with zero, all-ones and single-bit words mixed in.
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {{WORD_W-1{1'b0}}, 1'b1} << $urandom_range(0, WORD_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic block_t pattern_block(int k);
    block_t b;
    for (int i = 0; i < NUM_WORDS; i++) begin
      case (k)
        0: b[i] = '0;
        1: b[i] = '1;
        2: b[i] = 64'h1;
        3: b[i] = 64'h8000_0000_0000_0000;
        4: b[i] = (i % 2 == 0) ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA;
        default: b[i] = (i % 2 == 0) ? '0 : '1;
      endcase
    end
    return b;
  endfunction

  task automatic write_reg(input int idx, input logic [WORD_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(CFG_IDX_W'(idx), data);
  endtask

  // Writes every index, the unmapped ones included; those must be ignored.
  task automatic load_config(input cfg_set_t set);
    logic [WORD_W-1:0] data;
    for (int i = 0; i < 2 ** CFG_IDX_W; i++) begin
      case (set)
        SET_ZERO:   data = '0;
        SET_ONES:   data = '1;
        SET_RANDOM: data = {$urandom, $urandom};
        default:    data = rand_word();
      endcase
      if (i > CFG_TWEAK1) data = {$urandom, $urandom};
      write_reg(i, data);
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_block(input cmd_t dir, input block_t b);
    if (idle_on && $urandom_range(0, gap_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= dir;
    in_block_word_0 <= b[0];
    in_block_word_1 <= b[1];
    in_block_word_2 <= b[2];
    in_block_word_3 <= b[3];
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_block(dir, b);
  endtask

  task automatic run_phase(input cfg_set_t set, input bit directed, input int n_random,
                           input bit idle, input int unsigned odds);
    block_t b;
    // Registers may only change once the pipeline has drained.
    while (sb.pending() != 0) @(posedge clk);
    if (set != SET_KEEP) load_config(set);
    idle_on    = idle;
    stall_odds = odds;
    if (directed) begin
      for (int k = 0; k < 6; k++) begin
        send_block(CMD_ENC, pattern_block(k));
        send_block(CMD_DEC, pattern_block(k));
      end
    end
    for (int n = 0; n < n_random; n++) begin
      for (int i = 0; i < NUM_WORDS; i++) b[i] = rand_word();
      send_block(cmd_t'($urandom_range(0, 1)), b);
    end
    in_valid <= 1'b0;
  endtask

  // Receiver stalls in random bursts while idle_on is set; a short odds value keeps the chain full.
  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, stall_odds - 1) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_block({out_word_3, out_word_2, out_word_1, out_word_0});
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_cmd          <= CMD_ENC;
    in_block_word_0 <= '0;
    in_block_word_1 <= '0;
    in_block_word_2 <= '0;
    in_block_word_3 <= '0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= CFG_KEY0;
    cfg_wdata       <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The first phase runs on the all-zero key and tweak left by reset.
    run_phase(SET_KEEP,   1'b1, 60, 1'b1, 8);
    run_phase(SET_ONES,   1'b1, 60, 1'b1, 2);
    run_phase(SET_RANDOM, 1'b0, 75, 1'b1, 8);
    run_phase(SET_MIXED,  1'b0, 75, 1'b1, 2);
    run_phase(SET_ZERO,   1'b0, 75, 1'b0, 8);
    run_phase(SET_RANDOM, 1'b0, 75, 1'b1, 4);
    run_phase(SET_MIXED,  1'b0, 75, 1'b1, 2);
    run_phase(SET_RANDOM, 1'b0, 75, 1'b0, 8);

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/tf256_pkg.sv
rtl/core/tf256_keysched.sv
rtl/core/tf256_cell.sv
rtl/core/threefish256_block_cipher.sv
bench/testbench.sv
